@@ hw/rtl/fcs_pkg.sv @@
package fcs_pkg;

  localparam int unsigned MaxJoints = 16;
  localparam int unsigned IdxW      = $clog2(MaxJoints);
  localparam int unsigned CntW      = $clog2(MaxJoints + 1);
  localparam int unsigned CoordW    = 32;
  localparam int unsigned SqW       = 2 * CoordW;
  localparam int unsigned IterW     = $clog2(CoordW);
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned StepsW    = 8;
  localparam int unsigned ThrW      = 24;

  localparam logic [StepsW-1:0] NumStepsReset  = 8'd2;
  localparam logic [ThrW-1:0]   ThresholdReset = 24'd1;

  // register index codes (byte address / 4)
  localparam logic CfgNumSteps  = 1'b0;
  localparam logic CfgThreshold = 1'b1;

  localparam logic [1:0] ModeClear  = 2'd0;
  localparam logic [1:0] ModeAppend = 2'd1;
  localparam logic [1:0] ModeSolve  = 2'd2;

  typedef logic [2:0][CoordW-1:0] vec_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         joint_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               reached;
    logic               last_joint;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AP_LOAD,
    ST_DIST,
    ST_SQRT,
    ST_AP_WR,
    ST_SV_BASE,
    ST_CHK_RD,
    ST_CHK_LD,
    ST_CHK,
    ST_BW_WR,
    ST_PL_RD1,
    ST_PL_RD2,
    ST_PL_RD3,
    ST_PL_MUL,
    ST_PL_LOAD,
    ST_PL_DIV,
    ST_PL_ADD,
    ST_PL_WR,
    ST_FW_WR,
    ST_OUT_RD,
    ST_OUT_WAIT
  } state_e;

  typedef enum logic [1:0] {
    FL_APPEND,
    FL_CHECK,
    FL_PLACE
  } flow_e;

  function automatic logic [CoordW-1:0] sat32(input logic signed [CoordW+1:0] v);
    logic [CoordW-1:0] r;
    if (v > $signed({3'b000, {(CoordW-1){1'b1}}})) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < $signed({3'b111, {(CoordW-1){1'b0}}})) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/fabrik_chain_solver_top.sv @@
// FABRIK chain solver. Joint positions and bone lengths live in two single-port-read RAMs; one
// shared sequencer runs every step. A clear, and an append of the first joint, complete while the
// sequencer stays idle; any other append computes a distance, then a bit-per-cycle square root.
// A solve on n joints does a setup, then per round an early-exit check and, per bone placement,
// 3 RAM reads, a squared distance, a square root and three multiply/divide passes, one quotient
// bit per cycle. The n output words leave one at a time, each read from the joint RAM and then
// held until the output register is free. Input is taken only while
// the sequencer is idle; the output register lets the last words drain meanwhile.
module fabrik_chain_solver_top
  import fcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_e state_q, state_d;
  flow_e  flow_q, flow_d;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [StepsW-1:0] steps_q, steps_d, step_q, step_d;
  logic [ThrW-1:0]   thr_q, thr_d;
  logic [2*ThrW-1:0] thr_sq_q, thr_sq_d;
  vec_t goal_q, goal_d, base_q, base_d, a_q, a_d, b_q, b_d, new_q, new_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              bwd_q, bwd_d;
  logic [1:0]        cc_q, cc_d;
  logic [IterW-1:0]  it_q, it_d;
  logic [SqW-1:0]    acc_q, acc_d, prod_q, prod_d, sv_q, sv_d, sr_q, sr_d;
  logic [CoordW-1:0] lbone_q, lbone_d, rem_q, rem_d, low_q, low_d, quo_q, quo_d;
  logic              reached_q, reached_d;
  out_word_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              j_we, b_we;
  logic [IdxW-1:0]   j_waddr, j_raddr, b_waddr, b_raddr;
  vec_t              j_wdata, j_rdata;
  logic [CoordW-1:0] b_wdata, b_rdata;

  logic              in_fire, cfg_we, out_free;
  vec_t              in_vec;
  logic [IdxW-1:0]   last_idx;
  logic [CoordW-1:0] len, ac, bc, mag;
  logic signed [CoordW:0] df;
  logic [SqW:0]      acc_sum;
  logic [SqW-1:0]    acc_sat, bitv, trial;
  logic [CoordW:0]   dv_t;
  logic              dv_ge, lt_thr, a_neg;
  logic signed [CoordW+1:0] moved;

  fcs_ram #(.Width(3 * CoordW), .Depth(MaxJoints)) u_joint_ram (
    .clk_i   (clk_i),
    .we_i    (j_we),
    .waddr_i (j_waddr),
    .wdata_i (j_wdata),
    .raddr_i (j_raddr),
    .rdata_o (j_rdata)
  );

  fcs_ram #(.Width(CoordW), .Depth(MaxJoints)) u_bone_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[CfgAddrW-1] == CfgThreshold) ? {{(32-ThrW){1'b0}}, thr_q}
                                                      : {{(32-StepsW){1'b0}}, steps_q};

  assign in_vec[0] = in_data_i.pos_x;
  assign in_vec[1] = in_data_i.pos_y;
  assign in_vec[2] = in_data_i.pos_z;
  assign last_idx  = IdxW'(cnt_q - CntW'(1));
  assign len       = sr_q[CoordW-1:0];

  // component datapath
  always_comb begin
    case (cc_q)
      2'd0: begin
        ac = a_q[0];
        bc = b_q[0];
      end
      2'd1: begin
        ac = a_q[1];
        bc = b_q[1];
      end
      default: begin
        ac = a_q[2];
        bc = b_q[2];
      end
    endcase
    df      = $signed({ac[CoordW-1], ac}) - $signed({bc[CoordW-1], bc});
    a_neg   = df[CoordW];
    mag     = a_neg ? CoordW'(-df) : df[CoordW-1:0];
    acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
    acc_sat = acc_sum[SqW] ? '1 : acc_sum[SqW-1:0];
    bitv    = SqW'(1) << {it_q, 1'b0};
    trial   = sr_q + bitv;
    dv_t    = {rem_q, low_q[CoordW-1]};
    dv_ge   = dv_t >= {1'b0, len};
    lt_thr  = acc_q < {{(SqW-2*ThrW){1'b0}}, thr_sq_q};
    moved   = $signed({{2{bc[CoordW-1]}}, bc})
            + (a_neg ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.mode == ModeAppend && cnt_q < CntW'(MaxJoints) && cnt_q != '0) begin
            state_d = ST_AP_LOAD;
          end else if (in_data_i.mode == ModeSolve && cnt_q != '0) begin
            state_d = ST_SV_BASE;
          end
        end
      end
      ST_AP_LOAD: state_d = ST_DIST;
      ST_DIST: begin
        if (cc_q == 2'd3) begin
          state_d = (flow_q == FL_CHECK) ? ST_CHK : ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (it_q == '0) begin
          state_d = (flow_q == FL_APPEND) ? ST_AP_WR : ST_PL_MUL;
        end
      end
      ST_AP_WR:   state_d = ST_IDLE;
      ST_SV_BASE: state_d = ST_CHK_RD;
      ST_CHK_RD:  state_d = ST_CHK_LD;
      ST_CHK_LD:  state_d = ST_DIST;
      ST_CHK:     state_d = (lt_thr || step_q == steps_q) ? ST_OUT_RD : ST_BW_WR;
      ST_BW_WR:   state_d = (last_idx == '0) ? ST_FW_WR : ST_PL_RD1;
      ST_PL_RD1:  state_d = ST_PL_RD2;
      ST_PL_RD2:  state_d = ST_PL_RD3;
      ST_PL_RD3:  state_d = ST_DIST;
      ST_PL_MUL:  state_d = (len == '0) ? ST_PL_ADD : ST_PL_LOAD;
      ST_PL_LOAD: state_d = ST_PL_DIV;
      ST_PL_DIV:  state_d = (it_q == '0) ? ST_PL_ADD : ST_PL_DIV;
      ST_PL_ADD:  state_d = (cc_q == 2'd2) ? ST_PL_WR : ST_PL_MUL;
      ST_PL_WR: begin
        if (bwd_q) begin
          state_d = (idx_q == '0) ? ST_FW_WR : ST_PL_RD1;
        end else begin
          state_d = (idx_q == last_idx) ? ST_CHK_RD : ST_PL_RD1;
        end
      end
      ST_FW_WR:  state_d = (last_idx == '0) ? ST_CHK_RD : ST_PL_RD1;
      ST_OUT_RD: state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_free) begin
          state_d = (idx_q == last_idx) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    flow_d      = flow_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    thr_d       = thr_q;
    thr_sq_d    = thr_sq_q;
    step_d      = step_q;
    goal_d      = goal_q;
    base_d      = base_q;
    a_d         = a_q;
    b_d         = b_q;
    new_d       = new_q;
    idx_d       = idx_q;
    bwd_d       = bwd_q;
    cc_d        = cc_q;
    it_d        = it_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    sv_d        = sv_q;
    sr_d        = sr_q;
    lbone_d     = lbone_q;
    rem_d       = rem_q;
    low_d       = low_q;
    quo_d       = quo_q;
    reached_d   = reached_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    j_we        = 1'b0;
    j_waddr     = idx_q;
    j_wdata     = new_q;
    j_raddr     = idx_q;
    b_we        = 1'b0;
    b_waddr     = cnt_q[IdxW-1:0];
    b_wdata     = len;
    b_raddr     = idx_q;

    if (cfg_we) begin
      case (paddr[CfgAddrW-1])
        CfgNumSteps:  steps_d = pwdata[StepsW-1:0];
        CfgThreshold: thr_d   = pwdata[ThrW-1:0];
        default:      steps_d = steps_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.mode)
            ModeClear: cnt_d = '0;
            ModeAppend: begin
              if (cnt_q < CntW'(MaxJoints)) begin
                j_we    = 1'b1;
                j_waddr = cnt_q[IdxW-1:0];
                j_wdata = in_vec;
                a_d     = in_vec;
                flow_d  = FL_APPEND;
                j_raddr = last_idx;
                if (cnt_q == '0) begin
                  b_we    = 1'b1;
                  b_wdata = '0;
                  cnt_d   = CntW'(1);
                end
              end
            end
            ModeSolve: begin
              goal_d   = in_vec;
              j_raddr  = '0;
              thr_sq_d = (2*ThrW)'(thr_q) * (2*ThrW)'(thr_q);
              step_d   = '0;
            end
            default: cnt_d = cnt_q;
          endcase
        end
      end
      ST_AP_LOAD: begin
        b_d   = j_rdata;
        cc_d  = '0;
        acc_d = '0;
      end
      ST_DIST: begin
        // square one component while the previous square accumulates
        if (cc_q != 2'd3) begin
          prod_d = SqW'(mag) * SqW'(mag);
        end
        if (cc_q != 2'd0) begin
          acc_d = acc_sat;
        end
        cc_d = cc_q + 2'd1;
        sv_d = acc_sat;
        sr_d = '0;
        it_d = '1;
      end
      ST_SQRT: begin
        if (sv_q >= trial) begin
          sv_d = sv_q - trial;
          sr_d = (sr_q >> 1) + bitv;
        end else begin
          sr_d = sr_q >> 1;
        end
        it_d = it_q - IterW'(1);
        cc_d = '0;
      end
      ST_AP_WR: begin
        b_we  = 1'b1;
        cnt_d = cnt_q + CntW'(1);
      end
      ST_SV_BASE: base_d = j_rdata;
      ST_CHK_RD:  j_raddr = last_idx;
      ST_CHK_LD: begin
        a_d    = goal_q;
        b_d    = j_rdata;
        cc_d   = '0;
        acc_d  = '0;
        flow_d = FL_CHECK;
      end
      ST_CHK: begin
        reached_d = lt_thr;
        idx_d     = '0;
      end
      ST_BW_WR: begin
        j_we    = 1'b1;
        j_waddr = last_idx;
        j_wdata = goal_q;
        idx_d   = last_idx - IdxW'(1);
        bwd_d   = 1'b1;
      end
      ST_PL_RD1: begin
        j_raddr = idx_q;
        b_raddr = bwd_q ? idx_q + IdxW'(1) : idx_q;
      end
      ST_PL_RD2: begin
        a_d     = j_rdata;
        lbone_d = b_rdata;
        j_raddr = bwd_q ? idx_q + IdxW'(1) : idx_q - IdxW'(1);
      end
      ST_PL_RD3: begin
        b_d    = j_rdata;
        cc_d   = '0;
        acc_d  = '0;
        flow_d = FL_PLACE;
      end
      ST_PL_MUL: begin
        prod_d = SqW'(mag) * SqW'(lbone_q);
        quo_d  = '0;
      end
      ST_PL_LOAD: begin
        // quotient stays below 2^32, so the high half starts as the remainder
        rem_d = prod_q[SqW-1:CoordW];
        low_d = prod_q[CoordW-1:0];
        it_d  = '1;
      end
      ST_PL_DIV: begin
        rem_d = dv_ge ? CoordW'(dv_t - {1'b0, len}) : dv_t[CoordW-1:0];
        low_d = low_q << 1;
        quo_d = {quo_q[CoordW-2:0], dv_ge};
        it_d  = it_q - IterW'(1);
      end
      ST_PL_ADD: begin
        new_d[cc_q] = sat32(moved);
        cc_d        = cc_q + 2'd1;
      end
      ST_PL_WR: begin
        j_we = 1'b1;
        if (bwd_q) begin
          idx_d = idx_q - IdxW'(1);
        end else if (idx_q == last_idx) begin
          step_d = step_q + StepsW'(1);
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_FW_WR: begin
        j_we    = 1'b1;
        j_waddr = '0;
        j_wdata = base_q;
        idx_d   = IdxW'(1);
        bwd_d   = 1'b0;
        if (last_idx == '0) begin
          step_d = step_q + StepsW'(1);
        end
      end
      ST_OUT_RD: j_raddr = idx_q;
      ST_OUT_WAIT: begin
        if (out_free) begin
          out_d.joint_index = 4'(idx_q);
          out_d.out_x       = j_rdata[0];
          out_d.out_y       = j_rdata[1];
          out_d.out_z       = j_rdata[2];
          out_d.reached     = reached_q;
          out_d.last_joint  = (idx_q == last_idx);
          out_valid_d       = 1'b1;
          idx_d             = idx_q + IdxW'(1);
        end
      end
      default: idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flow_q      <= FL_APPEND;
      cnt_q       <= '0;
      steps_q     <= NumStepsReset;
      thr_q       <= ThresholdReset;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      bwd_q       <= 1'b0;
      cc_q        <= '0;
      it_q        <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      flow_q      <= flow_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      bwd_q       <= bwd_d;
      cc_q        <= cc_d;
      it_q        <= it_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q  <= thr_sq_d;
    goal_q    <= goal_d;
    base_q    <= base_d;
    a_q       <= a_d;
    b_q       <= b_d;
    new_q     <= new_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    sv_q      <= sv_d;
    sr_q      <= sr_d;
    lbone_q   <= lbone_d;
    rem_q     <= rem_d;
    low_q     <= low_d;
    quo_q     <= quo_d;
    reached_q <= reached_d;
    out_q     <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxJoints))
    else $error("joint count above capacity");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PL_ADD) |-> (quo_q <= lbone_q))
    else $error("bone offset exceeds bone length");

  a_sqrt_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT && it_q == '0) |=> (sr_q[SqW-1:CoordW] == '0))
    else $error("square root result wider than a coordinate");
`endif

endmodule

@@ hw/rtl/fcs_ram.sv @@
module fcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
